>>> hdl/weighted_histogram_fill_macros.svh
// Assertion macros used by the checker of the weighted histogram.
`ifndef WEIGHTED_HISTOGRAM_FILL_MACROS_SVH
`define WEIGHTED_HISTOGRAM_FILL_MACROS_SVH

// Next-cycle implication, off while reset is asserted.
`define WHF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define WHF_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/whf_pkg.sv
// Shared widths, codes, entry type and saturating adders of the weighted histogram.
`default_nettype none

package whf_pkg;

  localparam int unsigned BIN_DEPTH_DEF = 256;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned WTOT_W     = 48;
  localparam int unsigned WSUM_W     = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned RBIN_W     = 8;
  localparam int unsigned NBINS_W    = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW   = 2'd0,
    CFG_RANGE_HIGH  = 2'd1,
    CFG_BIN_SCALE   = 2'd2,
    CFG_BINS_IN_USE = 2'd3
  } cfg_idx_t;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST   = 32'd0;
  localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST  = 32'd65536;
  localparam logic [SAMPLE_W-1:0] BIN_SCALE_RST   = 32'd16777216;
  localparam logic [NBINS_W-1:0]  BINS_IN_USE_RST = 9'd256;

  localparam logic signed [WTOT_W-1:0] WTOT_MAX = {1'b0, {(WTOT_W-1){1'b1}}};
  localparam logic signed [WTOT_W-1:0] WTOT_MIN = {1'b1, {(WTOT_W-1){1'b0}}};
  localparam logic signed [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
  localparam logic signed [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [WTOT_W-1:0] weight_total;
    logic signed [WSUM_W-1:0] weighted_sum;
  } bin_entry_t;

  function automatic logic signed [WTOT_W-1:0] sat_add_wt(
    input logic signed [WTOT_W-1:0]   a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [WTOT_W:0] s;
    s = {a[WTOT_W-1], a} + {{(WTOT_W-SAMPLE_W+1){b[SAMPLE_W-1]}}, b};
    if (s[WTOT_W] != s[WTOT_W-1]) begin
      return s[WTOT_W] ? WTOT_MIN : WTOT_MAX;
    end
    return s[WTOT_W-1:0];
  endfunction

  function automatic logic signed [WSUM_W-1:0] sat_add_ws(
    input logic signed [WSUM_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic signed [WSUM_W:0] s;
    s = {a[WSUM_W-1], a} + {b[PROD_W-1], b};
    if (s[WSUM_W] != s[WSUM_W-1]) begin
      return s[WSUM_W] ? WSUM_MIN : WSUM_MAX;
    end
    return s[WSUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/whf_if.sv
// Valid/ready channel interfaces for the fill/read items and the read results.
`default_nettype none

interface whf_in_if;
  import whf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] weight;
  logic [RBIN_W-1:0]          read_bin;

  modport source (output valid, kind, sample, weight, read_bin, input ready);
  modport sink (input valid, kind, sample, weight, read_bin, output ready);
endinterface

interface whf_out_if;
  import whf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [RBIN_W-1:0]        bin_number;
  logic signed [WTOT_W-1:0] weight_total;
  logic signed [WSUM_W-1:0] weighted_sum;
  logic [CNT_W-1:0]         underflow_count;
  logic [CNT_W-1:0]         overflow_count;

  modport source (output valid, bin_number, weight_total, weighted_sum, underflow_count,
                  overflow_count, input ready);
  modport sink (input valid, bin_number, weight_total, weighted_sum, underflow_count,
                overflow_count, output ready);
endinterface

`default_nettype wire

>>> hdl/whf_bin_map.sv
// Multiplier stage: bin position from offset times scale, and sample times weight.
`default_nettype none

module whf_bin_map (
  input  logic                                clk,
  input  logic                                en,
  input  logic [whf_pkg::SAMPLE_W-1:0]        diff,
  input  logic [whf_pkg::SAMPLE_W-1:0]        scale,
  input  logic signed [whf_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [whf_pkg::SAMPLE_W-1:0] weight,
  output logic [whf_pkg::SAMPLE_W-1:0]        bin_raw,
  output logic signed [whf_pkg::PROD_W-1:0]   prod_sw
);
  import whf_pkg::*;

  logic [PROD_W-1:0]        prod_bin_nxt;
  logic [PROD_W-1:0]        prod_bin_r;
  logic signed [PROD_W-1:0] prod_sw_nxt;
  logic signed [PROD_W-1:0] prod_sw_r;

  always_comb begin
    prod_bin_nxt = PROD_W'(diff) * PROD_W'(scale);
    prod_sw_nxt  = PROD_W'(sample) * PROD_W'(weight);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_bin_r <= prod_bin_nxt;
      prod_sw_r  <= prod_sw_nxt;
    end
  end

  // Q16.16 offset times Q16.16 scale: integer bin sits in the upper word.
  assign bin_raw = prod_bin_r[PROD_W-1:SAMPLE_W];
  assign prod_sw = prod_sw_r;

endmodule

`default_nettype wire

>>> hdl/whf_store.sv
// Bin store: one write port, one read port, registered read data.
`default_nettype none

module whf_store #(
  parameter int unsigned BIN_DEPTH = whf_pkg::BIN_DEPTH_DEF,
  parameter int unsigned ADDR_W    = 8
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  whf_pkg::bin_entry_t     wdata,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       raddr,
  output whf_pkg::bin_entry_t     rdata
);
  import whf_pkg::*;

  bin_entry_t mem_r [BIN_DEPTH];
  bin_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/weighted_histogram_fill.sv
// Weighted histogram engine: top level with control sequencer and config registers.
//
// Input channel in_ch carries one item per transfer: kind selects fill or read.
// A fill with sample and weight either bumps the underflow or overflow counter or
// adds weight and sample*weight, both saturating, to one bin of the store.
// A read returns one result on out_ch: the bin's two totals and both counters.
// Items are handled one at a time through the store's read-modify-write path:
// an in-range fill passes the multiply, address and read-modify-write steps, an
// out-of-range fill only the multiply step, and a read all three before its result transfer.
// The result sits in an output register; a new item is taken while it waits.
// If out_ch stalls with a result still held, the next read waits in its last
// step until that register frees.
// Config writes (cfg_we, cfg_index, cfg_wdata) land at once, without handshake.
// After reset the block sweeps every entry of the store to zero with in_ch.ready low;
// counters and config registers return to their reset values.
`default_nettype none

module weighted_histogram_fill #(
  parameter int unsigned BIN_DEPTH = whf_pkg::BIN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  whf_in_if.sink                         in_ch,
  whf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [whf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import whf_pkg::*;

  localparam int unsigned ADDR_W = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
  localparam int unsigned NCNT_W = $clog2(BIN_DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_ADDR  = 5'b01000,
    ST_RMW   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic signed [SAMPLE_W-1:0] range_low_r;
  logic signed [SAMPLE_W-1:0] range_high_r;
  logic [SAMPLE_W-1:0]        bin_scale_r;
  logic [NBINS_W-1:0]         bins_in_use_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0]  below_cnt_r;
  logic [CNT_W-1:0]  above_cnt_r;

  logic                       kind_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] weight_r;
  logic [RBIN_W-1:0]          read_bin_r;
  logic                       below_r;
  logic                       above_r;
  logic [SAMPLE_W-1:0]        diff_r;
  logic [ADDR_W-1:0]          addr_r;
  logic [ADDR_W-1:0]          addr_nxt;
  logic                       rd_oob_r;

  logic                       out_valid_r;
  logic [RBIN_W-1:0]          out_bin_r;
  logic signed [WTOT_W-1:0]   out_wt_r;
  logic signed [WSUM_W-1:0]   out_ws_r;
  logic [CNT_W-1:0]           out_under_r;
  logic [CNT_W-1:0]           out_over_r;

  logic                       in_xfer;
  logic                       out_load;
  logic [SAMPLE_W-1:0]        bin_raw;
  logic signed [PROD_W-1:0]   prod_sw;
  logic [NCNT_W-1:0]          n_eff;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  bin_entry_t                 mem_wdata;
  bin_entry_t                 mem_rdata;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_RMW) && (kind_r == KIND_READ) &&
                       (!out_valid_r || out_ch.ready);

  whf_bin_map u_bin_map (
    .clk     (clk),
    .en      (state_r == ST_MUL),
    .diff    (diff_r),
    .scale   (bin_scale_r),
    .sample  (sample_r),
    .weight  (weight_r),
    .bin_raw (bin_raw),
    .prod_sw (prod_sw)
  );

  // Bins in use, held to 1..BIN_DEPTH.
  always_comb begin
    if (bins_in_use_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (32'(bins_in_use_r) > BIN_DEPTH) begin
      n_eff = NCNT_W'(BIN_DEPTH);
    end else begin
      n_eff = NCNT_W'(bins_in_use_r);
    end
  end

  // Clamp the bin into the last bin in use; a read goes straight to its bin.
  always_comb begin
    if (kind_r == KIND_READ) begin
      addr_nxt = ADDR_W'(read_bin_r);
    end else if (bin_raw >= SAMPLE_W'(n_eff)) begin
      addr_nxt = ADDR_W'(n_eff - NCNT_W'(1));
    end else begin
      addr_nxt = ADDR_W'(bin_raw);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end else if ((state_r == ST_RMW) && (kind_r == KIND_FILL)) begin
      mem_we                 = 1'b1;
      mem_wdata.weight_total = sat_add_wt(mem_rdata.weight_total, weight_r);
      mem_wdata.weighted_sum = sat_add_ws(mem_rdata.weighted_sum, prod_sw);
    end
  end

  whf_store #(
    .BIN_DEPTH (BIN_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state_r == ST_ADDR),
    .raddr (addr_nxt),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if ((kind_r == KIND_FILL) && (below_r || above_r)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_nxt = ST_RMW;
      end
      ST_RMW: begin
        if ((kind_r == KIND_FILL) || out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      below_cnt_r   <= '0;
      above_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
      range_low_r   <= RANGE_LOW_RST;
      range_high_r  <= RANGE_HIGH_RST;
      bin_scale_r   <= BIN_SCALE_RST;
      bins_in_use_r <= BINS_IN_USE_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if ((state_r == ST_MUL) && (kind_r == KIND_FILL)) begin
        // Below the low limit takes precedence when the limits are reversed.
        if (below_r) begin
          if (below_cnt_r != '1) begin
            below_cnt_r <= below_cnt_r + CNT_W'(1);
          end
        end else if (above_r && (above_cnt_r != '1)) begin
          above_cnt_r <= above_cnt_r + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RANGE_LOW:   range_low_r   <= cfg_wdata;
          CFG_RANGE_HIGH:  range_high_r  <= cfg_wdata;
          CFG_BIN_SCALE:   bin_scale_r   <= cfg_wdata;
          CFG_BINS_IN_USE: bins_in_use_r <= cfg_wdata[NBINS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Item and result payload, no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r     <= in_ch.kind;
      sample_r   <= in_ch.sample;
      weight_r   <= in_ch.weight;
      read_bin_r <= in_ch.read_bin;
      below_r    <= in_ch.sample < range_low_r;
      above_r    <= in_ch.sample > range_high_r;
      diff_r     <= SAMPLE_W'(in_ch.sample - range_low_r);
      rd_oob_r   <= 32'(in_ch.read_bin) >= BIN_DEPTH;
    end
    if (state_r == ST_ADDR) begin
      addr_r <= addr_nxt;
    end
    if (out_load) begin
      out_bin_r   <= read_bin_r;
      out_wt_r    <= rd_oob_r ? '0 : mem_rdata.weight_total;
      out_ws_r    <= rd_oob_r ? '0 : mem_rdata.weighted_sum;
      out_under_r <= below_cnt_r;
      out_over_r  <= above_cnt_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.bin_number      = out_bin_r;
  assign out_ch.weight_total    = out_wt_r;
  assign out_ch.weighted_sum    = out_ws_r;
  assign out_ch.underflow_count = out_under_r;
  assign out_ch.overflow_count  = out_over_r;

endmodule

`default_nettype wire

>>> hdl/whf_checker.sv
// Port-level assertions for the weighted histogram, bound to the top level.
`default_nettype none
`include "weighted_histogram_fill_macros.svh"

module whf_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [whf_pkg::RBIN_W-1:0]          out_bin_number,
  input wire logic signed [whf_pkg::WTOT_W-1:0]   out_weight_total,
  input wire logic signed [whf_pkg::WSUM_W-1:0]   out_weighted_sum,
  input wire logic [whf_pkg::CNT_W-1:0]           out_underflow_count,
  input wire logic [whf_pkg::CNT_W-1:0]           out_overflow_count
);
  import whf_pkg::*;

  localparam int unsigned PAYLOAD_W = RBIN_W + WTOT_W + WSUM_W + 2 * CNT_W;

  logic [PAYLOAD_W-1:0] out_payload;

  assign out_payload = {out_bin_number, out_weight_total, out_weighted_sum,
                        out_underflow_count, out_overflow_count};

  // Reset starts the clearing sweep: nothing taken, nothing offered.
  `WHF_ASSERT_RST(a_reset_quiet, !rst_n, !in_ready && !out_valid, "busy right after reset")

  // One item at a time: ready drops after each input transfer.
  `WHF_ASSERT(a_one_item, in_valid && in_ready, !in_ready, "ready held after transfer")

  `WHF_ASSERT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `WHF_ASSERT(a_out_stable, out_valid && !out_ready, $stable(out_payload), "result changed")

endmodule

bind weighted_histogram_fill whf_checker u_whf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_bin_number      (out_ch.bin_number),
  .out_weight_total    (out_ch.weight_total),
  .out_weighted_sum    (out_ch.weighted_sum),
  .out_underflow_count (out_ch.underflow_count),
  .out_overflow_count  (out_ch.overflow_count)
);

`default_nettype wire
